[sv/ggnc_pkg.sv]
package ggnc_pkg;

	localparam int VALUE_W   = 32;
	localparam int SUM_W     = 64;
	localparam int IN_DEPTH  = 4;
	localparam int OUT_DEPTH = 4;
	localparam int CNT_W     = $clog2(OUT_DEPTH) + 1;

	typedef enum logic [2:0] {
		CLS_MEASURE      = 3'b001,
		CLS_MEASURE_LAST = 3'b010,
		CLS_SCALE        = 3'b100
	} item_class_t;

	typedef struct packed {
		item_class_t        cls;
		logic               neg;
		logic [VALUE_W-1:0] mag;
		logic [VALUE_W-1:0] raw;
	} work_item_t;

	typedef struct packed {
		logic       valid;
		work_item_t item;
	} issue_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [VALUE_W-1:0] norm;
		logic               ready;
		logic               clip;
	} result_t;

endpackage

[sv/ggnc_fifo.sv]
module ggnc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     wr_en,
	input  logic [WIDTH-1:0]         wr_data,
	output logic                     full,
	input  logic                     rd_en,
	output logic [WIDTH-1:0]         rd_data,
	output logic                     empty,
	output logic [$clog2(DEPTH):0]   count
);

	localparam int AW = $clog2(DEPTH);

	logic [WIDTH-1:0] slots [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [AW:0]      count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == (AW+1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = slots[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (!do_wr && do_rd) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slots[wr_ptr_q] <= wr_data;
		end
	end

endmodule

[sv/ggnc_front.sv]
module ggnc_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic                          kind,
	input  logic [ggnc_pkg::VALUE_W-1:0]  grad_value,
	input  logic                          last,
	output ggnc_pkg::issue_t              issue,
	input  logic                          take
);

	import ggnc_pkg::*;

	work_item_t              in_item;
	logic [$bits(work_item_t)-1:0] q_data;
	logic                    q_empty;

	// Sort each request by pass and end marker, and take its magnitude early
	always_comb begin
		in_item.raw = grad_value;
		in_item.neg = grad_value[VALUE_W-1];
		in_item.mag = grad_value[VALUE_W-1] ? (VALUE_W'(0) - grad_value) : grad_value;
		if (kind) begin
			in_item.cls = CLS_SCALE;
		end else if (last) begin
			in_item.cls = CLS_MEASURE_LAST;
		end else begin
			in_item.cls = CLS_MEASURE;
		end
	end

	ggnc_fifo #(
		.WIDTH ($bits(work_item_t)),
		.DEPTH (IN_DEPTH)
	) u_in_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (in_item),
		.full    (full),
		.rd_en   (take),
		.rd_data (q_data),
		.empty   (q_empty),
		.count   ()
	);

	assign issue.valid = !q_empty;
	assign issue.item  = work_item_t'(q_data);

endmodule

[sv/ggnc_back.sv]
module ggnc_back #(
	parameter int FRAC_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ggnc_pkg::VALUE_W-1:0]  cfg_data,
	input  ggnc_pkg::issue_t              issue,
	output logic                          take,
	input  logic [ggnc_pkg::CNT_W-1:0]    out_count,
	output logic                          res_valid,
	output ggnc_pkg::result_t             res
);

	import ggnc_pkg::*;

	localparam int SCALE_W   = FRAC_BITS + 1;
	localparam int DIV_CNT_W = $clog2(FRAC_BITS);
	localparam logic [SCALE_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

	typedef enum logic [2:0] {
		ST_RUN  = 3'b001,
		ST_SQRT = 3'b010,
		ST_DIV  = 3'b100
	} seq_state_t;

	seq_state_t           state_q;
	logic [VALUE_W-1:0]   clip_limit_q;
	logic [SUM_W-1:0]     sum_q;
	logic [SCALE_W-1:0]   scale_q;
	logic [VALUE_W-1:0]   last_norm_q;

	logic                 valid_s1;
	work_item_t           item_s1;
	logic [SUM_W-1:0]     prod_s1;

	logic [SUM_W-1:0]     rem_q;
	logic [SUM_W-1:0]     root_q;
	logic [SUM_W-1:0]     bit_q;
	logic [VALUE_W-1:0]   hold_raw_q;
	logic [VALUE_W:0]     div_rem_q;
	logic [FRAC_BITS-1:0] quo_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;

	logic [VALUE_W-1:0]   mul_b;
	logic [CNT_W-1:0]     in_flight;
	logic                 s1_is_end;
	logic [SUM_W:0]       sum_add;
	logic [SUM_W-1:0]     sum_sat;
	logic [VALUE_W-1:0]   scaled_mag;
	logic [VALUE_W-1:0]   scaled_val;

	logic [SUM_W-1:0]     sq_trial;
	logic                 sq_ge;
	logic [SUM_W-1:0]     rem_next;
	logic [SUM_W-1:0]     root_next;
	logic [VALUE_W-1:0]   norm_next;
	logic                 sqrt_done;
	logic                 clip_needed;

	logic [VALUE_W:0]     dv_shift;
	logic                 dv_ge;
	logic [FRAC_BITS-1:0] quo_next;
	logic [SCALE_W-1:0]   scale_new;
	logic                 div_done;

	// Issue: hold while sequencer busy, end-of-pass in s1, or no result queue room
	assign s1_is_end = valid_s1 && (item_s1.cls == CLS_MEASURE_LAST);
	assign in_flight = out_count + CNT_W'(valid_s1);
	assign take      = issue.valid && (state_q == ST_RUN) && !s1_is_end
		&& (in_flight < CNT_W'(OUT_DEPTH));

	assign mul_b = (issue.item.cls == CLS_SCALE) ?
		{{(VALUE_W - SCALE_W){1'b0}}, scale_q} : issue.item.mag;

	assign sum_add = {1'b0, sum_q} + {1'b0, prod_s1};
	assign sum_sat = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];

	assign scaled_mag = prod_s1[FRAC_BITS +: VALUE_W];
	assign scaled_val = item_s1.neg ? (VALUE_W'(0) - scaled_mag) : scaled_mag;

	// Square root, one result bit per cycle
	assign sq_trial    = root_q + bit_q;
	assign sq_ge       = (rem_q >= sq_trial);
	assign rem_next    = sq_ge ? (rem_q - sq_trial) : rem_q;
	assign root_next   = sq_ge ? ((root_q >> 1) + bit_q) : (root_q >> 1);
	assign norm_next   = root_next[VALUE_W-1:0];
	assign sqrt_done   = (state_q == ST_SQRT) && bit_q[0];
	assign clip_needed = (clip_limit_q != '0) && (norm_next > clip_limit_q);

	// Restoring division of the clip limit by the norm, one quotient bit per cycle
	assign dv_shift  = {div_rem_q[VALUE_W-1:0], 1'b0};
	assign dv_ge     = (dv_shift >= {1'b0, last_norm_q});
	assign quo_next  = {quo_q[FRAC_BITS-2:0], dv_ge};
	assign scale_new = {1'b0, quo_next};
	assign div_done  = (state_q == ST_DIV) && (div_cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_RUN;
			valid_s1     <= 1'b0;
			clip_limit_q <= '0;
			sum_q        <= '0;
			scale_q      <= ONE;
			last_norm_q  <= '0;
		end else begin
			valid_s1 <= take;
			if (cfg_we) begin
				clip_limit_q <= cfg_data;
			end
			unique case (state_q)
				ST_RUN: begin
					if (valid_s1 && item_s1.cls == CLS_MEASURE) begin
						sum_q <= sum_sat;
					end else if (s1_is_end) begin
						sum_q   <= '0;
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					if (bit_q[0]) begin
						last_norm_q <= norm_next;
						if (clip_needed) begin
							state_q <= ST_DIV;
						end else begin
							scale_q <= ONE;
							state_q <= ST_RUN;
						end
					end
				end
				ST_DIV: begin
					if (div_cnt_q == '0) begin
						scale_q <= scale_new;
						state_q <= ST_RUN;
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= issue.item;
			prod_s1 <= {{(SUM_W - VALUE_W){1'b0}}, issue.item.mag}
				* {{(SUM_W - VALUE_W){1'b0}}, mul_b};
		end
		if (state_q == ST_RUN && s1_is_end) begin
			rem_q      <= sum_sat;
			root_q     <= '0;
			bit_q      <= {2'b01, {(SUM_W - 2){1'b0}}};
			hold_raw_q <= item_s1.raw;
		end
		if (state_q == ST_SQRT) begin
			rem_q     <= rem_next;
			root_q    <= root_next;
			bit_q     <= bit_q >> 2;
			div_rem_q <= {1'b0, clip_limit_q};
			quo_q     <= '0;
			div_cnt_q <= DIV_CNT_W'(FRAC_BITS - 1);
		end
		if (state_q == ST_DIV) begin
			div_rem_q <= dv_ge ? (dv_shift - {1'b0, last_norm_q}) : dv_shift;
			quo_q     <= quo_next;
			div_cnt_q <= div_cnt_q - 1'b1;
		end
	end

	always_comb begin
		res_valid = 1'b0;
		res       = '0;
		if (state_q == ST_RUN && valid_s1) begin
			unique case (item_s1.cls)
				CLS_MEASURE: begin
					res_valid = 1'b1;
					res.value = item_s1.raw;
					res.norm  = last_norm_q;
					res.clip  = (scale_q < ONE);
				end
				CLS_SCALE: begin
					res_valid = 1'b1;
					res.value = scaled_val;
					res.norm  = last_norm_q;
					res.clip  = (scale_q < ONE);
				end
				default: begin
					res_valid = 1'b0;
				end
			endcase
		end else if (sqrt_done && !clip_needed) begin
			res_valid = 1'b1;
			res.value = hold_raw_q;
			res.norm  = norm_next;
			res.ready = 1'b1;
		end else if (div_done) begin
			res_valid = 1'b1;
			res.value = hold_raw_q;
			res.norm  = last_norm_q;
			res.ready = 1'b1;
			res.clip  = (scale_new < ONE);
		end
	end

`ifndef SYNTH
	a_credit: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (out_count < CNT_W'(OUT_DEPTH)))
		else $error("result written with no room in result queue");

	a_busy_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_RUN) |-> !valid_s1)
		else $error("stage 1 occupied while sequencer busy");

	a_take_run: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> (state_q == ST_RUN))
		else $error("request taken while sequencer busy");

	a_scale_max: assert property (@(posedge clk) disable iff (!arst_n)
		scale_q <= ONE)
		else $error("scale above one");

	a_end_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && s1_is_end) |=> (state_q == ST_SQRT))
		else $error("end of measure pass did not start square root");
`endif

endmodule

[sv/grad_global_norm_clip_core.sv]
// Channel   Direction  Handshake                  Payload
// input     in         push / full                kind, grad_value, last
// result    out        pop / empty                value_out, norm_out, norm_ready, clip_active
// config    in         cfg_we (no wait)           cfg_data -> clip limit
//
// Ordinary elements stream at one per cycle while the back end is idle and the result queue has
// room, via the input queue and stage s1. An end-of-measure element holds the back end for its
// square root (one root bit a cycle), plus restoring division if a nonzero limit is exceeded.
// Reset clears queues, sums and norm and sets scale to one at once; there is no clearing pass.
// A full result queue stalls the back end; the input queue then fills and raises full.
module grad_global_norm_clip_core #(
	parameter int FRAC_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic                          kind,
	input  logic [ggnc_pkg::VALUE_W-1:0]  grad_value,
	input  logic                          last,
	output logic                          empty,
	input  logic                          pop,
	output logic [ggnc_pkg::VALUE_W-1:0]  value_out,
	output logic [ggnc_pkg::VALUE_W-1:0]  norm_out,
	output logic                          norm_ready,
	output logic                          clip_active,
	input  logic                          cfg_we,
	input  logic [ggnc_pkg::VALUE_W-1:0]  cfg_data
);

	import ggnc_pkg::*;

	issue_t                     issue;
	logic                       take;
	logic                       res_valid;
	result_t                    res;
	result_t                    res_head;
	logic [$bits(result_t)-1:0] res_data;
	logic [CNT_W-1:0]           out_count;

	ggnc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.kind       (kind),
		.grad_value (grad_value),
		.last       (last),
		.issue      (issue),
		.take       (take)
	);

	ggnc_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.issue     (issue),
		.take      (take),
		.out_count (out_count),
		.res_valid (res_valid),
		.res       (res)
	);

	ggnc_fifo #(
		.WIDTH ($bits(result_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_valid),
		.wr_data (res),
		.full    (),
		.rd_en   (pop),
		.rd_data (res_data),
		.empty   (empty),
		.count   (out_count)
	);

	assign res_head    = result_t'(res_data);
	assign value_out   = res_head.value;
	assign norm_out    = res_head.norm;
	assign norm_ready  = res_head.ready;
	assign clip_active = res_head.clip;

endmodule
